[hw/rtl/wbps_pkg.sv]
// wbps_pkg: shared constants and types for the wildcard byte pattern scanner
// no dependencies; used by the channel interfaces and the scanner top level
`default_nettype none

package wbps_pkg;

   // pattern geometry
   localparam int MAX_PATTERN_BYTES = 32;
   localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
   localparam int LEN_W             = 6;
   localparam int WORD_W            = 64;
   localparam int WORDS             = (MAX_PATTERN_BYTES * 8 + WORD_W - 1) / WORD_W;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 32;
   localparam int COUNT_W  = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_WILDCARD_MASK  = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5
   } csr_index_type;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

   // result payload held in the output register
   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/wbps_req_if.sv]
// wbps_req_if: input byte channel of the scanner (valid/ready plus payload)
// depends on wbps_pkg
`default_nettype none

interface wbps_req_if
   import wbps_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/wbps_rsp_if.sv]
// wbps_rsp_if: result channel of the scanner (valid/ready plus payload)
// depends on wbps_pkg
`default_nettype none

interface wbps_rsp_if
   import wbps_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] match_offset;

   modport source (output valid, found, match_offset, input ready);
   modport sink   (input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

[hw/rtl/wildcard_byte_pattern_scanner.sv]
// wildcard_byte_pattern_scanner: streaming search for a wildcard byte pattern
// depends on wbps_pkg, wbps_req_if, wbps_rsp_if
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------
//   req_ch   | in  | valid/ready      | data_byte[7:0], last_byte
//   rsp_ch   | out | valid/ready      | found, match_offset[31:0]
//   csr_*    | in  | csr_we only      | csr_index[2:0], csr_wdata[63:0]
//
// one item per cycle while no result stalls; an item is compared in the input
// register and a match or end-of-stream result is then registered in the
// output register. a register write passes the configuration registers, then
// the aligned pattern registers. reset is synchronous and clears the stream
// state, configuration registers and valid flags. a stalled result holds the
// output and input registers; items flow again as soon as the result drains.
`default_nettype none

module wildcard_byte_pattern_scanner
   import wbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   wbps_req_if.sink                   req_ch,
   wbps_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_W = MAX_PATTERN_BYTES * BYTE_W;

   // configuration registers
   logic [WORDS*WORD_W-1:0]        pattern_ff;
   logic [MAX_PATTERN_BYTES-1:0]   wildcard_ff;
   logic [LEN_W-1:0]               length_ff;

   // pattern aligned to window order, derived from configuration
   logic [WIN_W-1:0]               aligned_pat_ff, aligned_pat_in;
   logic [MAX_PATTERN_BYTES-1:0]   aligned_care_ff, aligned_care_in;
   logic [LEN_W-1:0]               len_used_ff, len_used_in;

   // input register
   logic                           in_valid_ff;
   logic [BYTE_W-1:0]              in_data_ff;
   logic                           in_last_ff;

   // stream state
   logic [WIN_W-1:0]               window_ff, window_in;
   logic [COUNT_W-1:0]             count_ff, count_in;
   logic                           reported_ff, reported_in;

   // output register
   logic                           rsp_valid_ff;
   result_type                     rsp_ff, rsp_in;

   logic                           req_take;
   logic                           proc_go;
   logic                           emit;
   logic                           counting;
   logic [COUNT_W-1:0]             count_next;
   logic [WIN_W-1:0]               window_shift;
   logic [MAX_PATTERN_BYTES-1:0]   byte_ok;
   logic                           window_hit;
   logic                           found_hit;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         wildcard_ff <= '0;
         length_ff   <= LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: pattern_ff[0*WORD_W +: WORD_W] <= csr_wdata;
            CSR_PATTERN_WORD_1: pattern_ff[1*WORD_W +: WORD_W] <= csr_wdata;
            CSR_PATTERN_WORD_2: pattern_ff[2*WORD_W +: WORD_W] <= csr_wdata;
            CSR_PATTERN_WORD_3: pattern_ff[3*WORD_W +: WORD_W] <= csr_wdata;
            CSR_WILDCARD_MASK:  wildcard_ff <= csr_wdata[MAX_PATTERN_BYTES-1:0];
            CSR_PATTERN_LENGTH: length_ff   <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp length and reverse the pattern so byte j lines up with window entry j
   always_comb begin
      logic [PAT_IDX_W-1:0] k;
      if (length_ff == '0) begin
         len_used_in = LEN_W'(1);
      end else if (length_ff > LEN_W'(MAX_PATTERN_BYTES)) begin
         len_used_in = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         len_used_in = length_ff;
      end
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         k = PAT_IDX_W'(len_used_in - LEN_W'(1) - LEN_W'(j));
         aligned_pat_in[j*BYTE_W +: BYTE_W] = pattern_ff[k*BYTE_W +: BYTE_W];
         aligned_care_in[j] = (LEN_W'(j) < len_used_in) && !wildcard_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      aligned_pat_ff  <= aligned_pat_in;
      aligned_care_ff <= aligned_care_in;
      len_used_ff     <= len_used_in;
   end

   // handshake
   assign proc_go      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || proc_go;
   assign req_take     = req_ch.valid && req_ch.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
   end

   // window compare and result
   assign counting     = (count_ff != '1);
   assign count_next   = count_ff + COUNT_W'(1);
   assign window_shift = {window_ff[WIN_W-BYTE_W-1:0], in_data_ff};

   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         byte_ok[j] = !aligned_care_ff[j] ||
                      (window_shift[j*BYTE_W +: BYTE_W] == aligned_pat_ff[j*BYTE_W +: BYTE_W]);
      end
   end

   assign window_hit = &byte_ok;
   assign found_hit  = counting && !reported_ff &&
                       (count_next >= COUNT_W'(len_used_ff)) && window_hit;
   assign emit       = found_hit || (in_last_ff && !reported_ff);

   always_comb begin
      rsp_in.found        = found_hit;
      rsp_in.match_offset = found_hit ? OFFSET_W'(count_next - COUNT_W'(len_used_ff)) : '0;
   end

   // next stream state
   always_comb begin
      window_in   = window_ff;
      count_in    = count_ff;
      reported_in = reported_ff;
      if (in_last_ff) begin
         window_in   = '0;
         count_in    = '0;
         reported_in = 1'b0;
      end else if (counting) begin
         window_in   = window_shift;
         count_in    = count_next;
         reported_in = reported_ff || found_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (proc_go) begin
         window_ff   <= window_in;
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_go && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_ff.found;
   assign rsp_ch.match_offset = rsp_ff.match_offset;

   // no second match inside one stream
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && reported_ff) |-> !found_hit)
      else $error("second match reported in one stream");

   // last item clears the stream state
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && in_last_ff) |=> (count_ff == '0) && !reported_ff)
      else $error("stream state not cleared after last item");

   // output register only loads when it is free
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && emit) |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result overwritten while stalled");

   // a reported offset lies inside the bytes seen so far
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && found_hit) |-> (rsp_in.match_offset < count_next))
      else $error("match offset beyond byte count");

endmodule

`default_nettype wire
